FILE: rtl/wnms_pkg.sv
// shared types and constants of the windowed non-maximum suppression block
package wnms_pkg;

  // defaults for the top-level parameters
  localparam int MAX_RADIUS_DEF   = 16;
  localparam int MAX_CHANNELS_DEF = 4;

  // fixed field widths
  localparam int SAMPLE_BITS = 32;
  localparam int RAD_W       = 5;
  localparam int CNT_W       = 3;
  localparam int SEEN_W      = 6;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 5;

  // widths that cover the whole parameter range (radius up to 16, four channels)
  localparam int AGE_W    = 5;
  localparam int CH_LIM_W = 2;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 6'd63;

  // job queue between front and back end, power of two deep
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT = 1'd1;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // one decision: sample of channel ch at age (0 = newest), window ages 0..hi
  typedef struct packed {
    logic [CH_LIM_W-1:0] ch;
    logic [AGE_W-1:0]    age;
    logic [AGE_W-1:0]    hi;
    logic [AGE_W-1:0]    wp;
    logic                fin;
  } wnms_job_t;

  // history write from the front end
  typedef struct packed {
    logic                en;
    logic [CH_LIM_W-1:0] ch;
    logic [AGE_W-1:0]    ptr;
    sample_t             data;
  } wnms_wr_t;

endpackage

FILE: rtl/windowed_non_max_suppression_unit.sv
// top level of the windowed non-maximum suppression block
// Streaming 1-D non-maximum suppression over interleaved Q16.16 channels. A
// sample is passed on when no sample of its own channel from radius before to
// radius-1 after it (clipped to the data set) is strictly greater, else zero
// is sent. Results trail their inputs by radius-1 samples per channel; the
// input with set_end flushes everything pending, oldest frame first and
// channels in ascending order, and marks the last result with final_result.
// One input transaction is taken at a time: the front end writes the sample to
// the history memory and queues decision jobs, and the next input is only taken
// once the back end has drained them. Each decision walks the window through
// the single history read port, one stored sample per cycle. An input with
// set_end adds a scan over the pending ages of every channel and a window walk
// for every flushed result. A waiting result sits in an output register and
// does not block the next input. Configuration writes are taken in any cycle;
// change them only while no transaction is in flight.
module windowed_non_max_suppression_unit #(
  parameter int MAX_RADIUS   = wnms_pkg::MAX_RADIUS_DEF,
  parameter int MAX_CHANNELS = wnms_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input samples
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wnms_pkg::sample_t                 in_sample_value,
  input  logic                              in_set_end,
  // results
  output logic                              out_valid,
  input  logic                              out_ready,
  output wnms_pkg::sample_t                 out_kept_value,
  output logic                              out_final_result,
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wnms_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wnms_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import wnms_pkg::*;

  logic [RAD_W-1:0] radius_r, radius_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  logic      q_push_valid, q_push_ready;
  wnms_job_t q_push_job;
  logic      q_pop_valid, q_pop_ready;
  wnms_job_t q_pop_job;
  logic      q_empty;
  logic      back_idle;
  wnms_wr_t  hist_wr;

  // register port never stalls
  assign cfg_ready = 1'b1;

  always_comb begin
    radius_nxt = radius_r;
    count_nxt  = count_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        CFG_WINDOW_RADIUS: radius_nxt = cfg_data[RAD_W-1:0];
        CFG_CHANNEL_COUNT: count_nxt  = cfg_data[CNT_W-1:0];
        default: begin
          radius_nxt = radius_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RAD_W'(1);
      count_r  <= CNT_W'(1);
    end else begin
      radius_r <= radius_nxt;
      count_r  <= count_nxt;
    end
  end

  // front end: bookkeeping per channel, history writes, job generation
  wnms_front #(
    .MAX_RADIUS   (MAX_RADIUS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_radius      (radius_r),
    .cfg_count       (count_r),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_value (in_sample_value),
    .in_set_end      (in_set_end),
    .back_idle       (back_idle),
    .q_empty         (q_empty),
    .q_push_valid    (q_push_valid),
    .q_push_ready    (q_push_ready),
    .q_push_job      (q_push_job),
    .hist_wr         (hist_wr)
  );

  // jobs in flight between the two halves
  wnms_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_job   (q_push_job),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_job    (q_pop_job),
    .empty      (q_empty)
  );

  // back end: window walk and result register
  wnms_back #(
    .MAX_RADIUS   (MAX_RADIUS),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .hist_wr          (hist_wr),
    .pop_valid        (q_pop_valid),
    .pop_ready        (q_pop_ready),
    .pop_job          (q_pop_job),
    .back_idle        (back_idle),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kept_value   (out_kept_value),
    .out_final_result (out_final_result)
  );

endmodule

FILE: rtl/wnms_queue.sv
// small job queue between the front and back end
module wnms_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  wnms_pkg::wnms_job_t push_job,
  output logic                pop_valid,
  input  logic                pop_ready,
  output wnms_pkg::wnms_job_t pop_job,
  output logic                empty
);
  import wnms_pkg::*;

  wnms_job_t          entry_r [QUEUE_DEPTH];
  logic [QIDX_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QIDX_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;
  logic               do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign empty      = (count_r == '0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QIDX_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + QIDX_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/wnms_front.sv
// front end: takes samples, keeps per-channel counts and pointers, issues decision jobs
module wnms_front #(
  parameter int MAX_RADIUS   = wnms_pkg::MAX_RADIUS_DEF,
  parameter int MAX_CHANNELS = wnms_pkg::MAX_CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [wnms_pkg::RAD_W-1:0]        cfg_radius,
  input  logic [wnms_pkg::CNT_W-1:0]        cfg_count,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  wnms_pkg::sample_t                 in_sample_value,
  input  logic                              in_set_end,
  input  logic                              back_idle,
  input  logic                              q_empty,
  output logic                              q_push_valid,
  input  logic                              q_push_ready,
  output wnms_pkg::wnms_job_t               q_push_job,
  output wnms_pkg::wnms_wr_t                hist_wr
);
  import wnms_pkg::*;

  localparam int HP_W = $clog2(2 * MAX_RADIUS);
  localparam int CH_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [2:0] {
    F_IDLE  = 3'b001,
    F_FLUSH = 3'b010,
    F_LAST  = 3'b100
  } front_state_t;

  front_state_t       state_r, state_nxt;
  logic [CH_W-1:0]    pos_r, pos_nxt;
  logic [CH_W-1:0]    item_pos_r, item_pos_nxt;
  logic               end_r, end_nxt;
  logic [HP_W-1:0]    k_r, k_nxt;
  logic [CH_W-1:0]    fch_r, fch_nxt;
  wnms_job_t          pend_r, pend_nxt;
  logic               pend_v_r, pend_v_nxt;
  logic [SEEN_W-1:0]  seen_r [MAX_CHANNELS];
  logic [SEEN_W-1:0]  seen_nxt [MAX_CHANNELS];
  logic [HP_W-1:0]    wp_r [MAX_CHANNELS];
  logic [HP_W-1:0]    wp_nxt [MAX_CHANNELS];

  logic [RAD_W-1:0]   r_eff;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CH_W-1:0]    pos_w;
  logic [CH_W-1:0]    sel_ch;
  logic [SEEN_W-1:0]  seen_sel;
  logic [HP_W-1:0]    wp_sel;
  logic [SEEN_W-1:0]  r_ext;
  logic [SEEN_W-1:0]  seen_new;
  logic [SEEN_W-1:0]  two_r_m1;
  logic [SEEN_W-1:0]  norm_hi;
  logic               norm_ok;
  logic               shift;
  logic [HP_W-1:0]    age;
  logic [SEEN_W-1:0]  p_lim;
  logic [SEEN_W-1:0]  cand_sum;
  logic [SEEN_W-1:0]  cand_hi;
  logic               cand_ok;
  logic               chan_last;
  logic               in_acc;

  // out-of-range settings act as the nearest legal value
  always_comb begin
    if (cfg_radius == '0) begin
      r_eff = RAD_W'(1);
    end else if (cfg_radius > RAD_W'(MAX_RADIUS)) begin
      r_eff = RAD_W'(MAX_RADIUS);
    end else begin
      r_eff = cfg_radius;
    end
    if (cfg_count == '0) begin
      cnt_eff = CNT_W'(1);
    end else if (cfg_count > CNT_W'(MAX_CHANNELS)) begin
      cnt_eff = CNT_W'(MAX_CHANNELS);
    end else begin
      cnt_eff = cfg_count;
    end
  end

  assign pos_w    = (CNT_W'(pos_r) >= cnt_eff) ? '0 : pos_r;
  assign sel_ch   = (state_r == F_FLUSH) ? fch_r : pos_w;
  assign seen_sel = seen_r[sel_ch];
  assign wp_sel   = wp_r[sel_ch];
  assign r_ext    = SEEN_W'(r_eff);

  assign in_ready = (state_r == F_IDLE) && q_empty && back_idle;
  assign in_acc   = in_valid && in_ready;

  // decision for the sample radius-1 behind the new one
  assign seen_new = (seen_sel == SEEN_MAX) ? seen_sel : seen_sel + SEEN_W'(1);
  assign norm_ok  = (seen_new >= r_ext);
  assign two_r_m1 = (r_ext << 1) - SEEN_W'(1);
  assign norm_hi  = (two_r_m1 < seen_new - SEEN_W'(1)) ? two_r_m1 : seen_new - SEEN_W'(1);

  // flush scan, oldest frame first; channels after the last input are one age behind
  assign shift     = (fch_r > item_pos_r);
  assign age       = k_r - HP_W'(shift);
  assign p_lim     = (seen_sel < r_ext - SEEN_W'(1)) ? seen_sel : r_ext - SEEN_W'(1);
  assign cand_ok   = (k_r >= HP_W'(shift)) && (SEEN_W'(age) < p_lim);
  assign cand_sum  = SEEN_W'(age) + r_ext;
  assign cand_hi   = (cand_sum < seen_sel - SEEN_W'(1)) ? cand_sum : seen_sel - SEEN_W'(1);
  assign chan_last = (CNT_W'(fch_r) + CNT_W'(1) >= cnt_eff);

  always_comb begin
    state_nxt    = state_r;
    pos_nxt      = pos_r;
    item_pos_nxt = item_pos_r;
    end_nxt      = end_r;
    k_nxt        = k_r;
    fch_nxt      = fch_r;
    pend_nxt     = pend_r;
    pend_v_nxt   = pend_v_r;
    seen_nxt     = seen_r;
    wp_nxt       = wp_r;
    q_push_valid = 1'b0;
    hist_wr      = '0;

    unique case (state_r)
      F_IDLE: begin
        if (in_acc) begin
          hist_wr.en      = 1'b1;
          hist_wr.ch      = CH_LIM_W'(pos_w);
          hist_wr.ptr     = AGE_W'(wp_sel);
          hist_wr.data    = in_sample_value;
          wp_nxt[pos_w]   = wp_sel + HP_W'(1);
          seen_nxt[pos_w] = seen_new;
          pend_v_nxt      = norm_ok;
          pend_nxt.ch     = CH_LIM_W'(pos_w);
          pend_nxt.age    = AGE_W'(r_eff - RAD_W'(1));
          pend_nxt.hi     = AGE_W'(norm_hi);
          pend_nxt.wp     = AGE_W'(wp_sel + HP_W'(1));
          pend_nxt.fin    = 1'b0;
          item_pos_nxt    = pos_w;
          end_nxt         = in_set_end;
          if (in_set_end) begin
            state_nxt = F_FLUSH;
            k_nxt     = HP_W'(r_eff - RAD_W'(1));
            fch_nxt   = '0;
          end else begin
            state_nxt = F_LAST;
            pos_nxt   = (CNT_W'(pos_w) + CNT_W'(1) >= cnt_eff) ? '0 : pos_w + CH_W'(1);
          end
        end
      end
      F_FLUSH: begin
        if (!(cand_ok && pend_v_r && !q_push_ready)) begin
          if (cand_ok) begin
            q_push_valid = pend_v_r;
            pend_v_nxt   = 1'b1;
            pend_nxt.ch  = CH_LIM_W'(fch_r);
            pend_nxt.age = AGE_W'(age);
            pend_nxt.hi  = AGE_W'(cand_hi);
            pend_nxt.wp  = AGE_W'(wp_sel);
            pend_nxt.fin = 1'b0;
          end
          if (chan_last) begin
            if (k_r == '0) begin
              // end of set: counts and channel position start over
              state_nxt = F_LAST;
              pos_nxt   = '0;
              for (int i = 0; i < MAX_CHANNELS; i++) begin
                seen_nxt[i] = '0;
              end
            end else begin
              k_nxt   = k_r - HP_W'(1);
              fch_nxt = '0;
            end
          end else begin
            fch_nxt = fch_r + CH_W'(1);
          end
        end
      end
      F_LAST: begin
        if (pend_v_r) begin
          q_push_valid = 1'b1;
          if (q_push_ready) begin
            pend_v_nxt = 1'b0;
            state_nxt  = F_IDLE;
          end
        end else begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  // the held job goes out last, so only here is it known to close the set
  always_comb begin
    q_push_job     = pend_r;
    q_push_job.fin = (state_r == F_LAST) && end_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= F_IDLE;
      pos_r    <= '0;
      pend_v_r <= 1'b0;
      end_r    <= 1'b0;
      k_r      <= '0;
      fch_r    <= '0;
      for (int i = 0; i < MAX_CHANNELS; i++) begin
        seen_r[i] <= '0;
        wp_r[i]   <= '0;
      end
    end else begin
      state_r  <= state_nxt;
      pos_r    <= pos_nxt;
      pend_v_r <= pend_v_nxt;
      end_r    <= end_nxt;
      k_r      <= k_nxt;
      fch_r    <= fch_nxt;
      seen_r   <= seen_nxt;
      wp_r     <= wp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_r     <= pend_nxt;
    item_pos_r <= item_pos_nxt;
  end

endmodule

FILE: rtl/wnms_back.sv
// back end: history memory, shared max walk over the window, output register
module wnms_back #(
  parameter int MAX_RADIUS   = wnms_pkg::MAX_RADIUS_DEF,
  parameter int MAX_CHANNELS = wnms_pkg::MAX_CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  wnms_pkg::wnms_wr_t  hist_wr,
  input  logic                pop_valid,
  output logic                pop_ready,
  input  wnms_pkg::wnms_job_t pop_job,
  output logic                back_idle,
  output logic                out_valid,
  input  logic                out_ready,
  output wnms_pkg::sample_t   out_kept_value,
  output logic                out_final_result
);
  import wnms_pkg::*;

  localparam int HP_W       = $clog2(2 * MAX_RADIUS);
  localparam int HIST_DEPTH = 1 << HP_W;
  localparam int CH_W       = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

  typedef enum logic [2:0] {
    B_IDLE = 3'b001,
    B_WALK = 3'b010,
    B_DONE = 3'b100
  } back_state_t;

  sample_t         mem [MAX_CHANNELS][HIST_DEPTH];

  back_state_t     state_r, state_nxt;
  wnms_job_t       job_r, job_nxt;
  logic [HP_W-1:0] k_r, k_nxt;
  logic            iss_done_r, iss_done_nxt;
  logic            rd_valid_r, rd_valid_nxt;
  logic [HP_W-1:0] rd_tag_r;
  sample_t         rd_data_r;
  sample_t         max_r, max_nxt;
  sample_t         cur_r, cur_nxt;
  logic            out_valid_r, out_valid_nxt;
  sample_t         out_value_r, out_value_nxt;
  logic            out_final_r, out_final_nxt;

  logic            issue;
  logic            out_free;
  logic [HP_W-1:0] rd_ptr;
  logic [HP_W-1:0] hi_w;

  assign back_idle        = (state_r == B_IDLE);
  assign pop_ready        = (state_r == B_IDLE);
  assign out_valid        = out_valid_r;
  assign out_kept_value   = out_value_r;
  assign out_final_result = out_final_r;

  assign hi_w     = job_r.hi[HP_W-1:0];
  assign issue    = (state_r == B_WALK) && !iss_done_r;
  assign out_free = !out_valid_r || out_ready;
  // age k sits k+1 places behind the write pointer
  assign rd_ptr   = job_r.wp[HP_W-1:0] - HP_W'(1) - k_r;

  always_ff @(posedge clk) begin
    if (hist_wr.en) begin
      mem[hist_wr.ch[CH_W-1:0]][hist_wr.ptr[HP_W-1:0]] <= hist_wr.data;
    end
    rd_data_r <= mem[job_r.ch[CH_W-1:0]][rd_ptr];
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    k_nxt         = k_r;
    iss_done_nxt  = iss_done_r;
    rd_valid_nxt  = issue;
    max_nxt       = max_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;

    // running maximum; the sample is kept when nothing beats it
    if (rd_valid_r) begin
      if ((rd_tag_r == '0) || (rd_data_r > max_r)) begin
        max_nxt = rd_data_r;
      end
      if (rd_tag_r == job_r.age[HP_W-1:0]) begin
        cur_nxt = rd_data_r;
      end
    end

    unique case (state_r)
      B_IDLE: begin
        if (pop_valid) begin
          job_nxt      = pop_job;
          k_nxt        = '0;
          iss_done_nxt = 1'b0;
          state_nxt    = B_WALK;
        end
      end
      B_WALK: begin
        if (issue) begin
          if (k_r == hi_w) begin
            iss_done_nxt = 1'b1;
          end else begin
            k_nxt = k_r + HP_W'(1);
          end
        end
        if (rd_valid_r && (rd_tag_r == hi_w)) begin
          state_nxt = B_DONE;
        end
      end
      B_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (max_r == cur_r) ? cur_r : '0;
          out_final_nxt = job_r.fin;
          state_nxt     = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      iss_done_r  <= 1'b1;
      rd_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_done_r  <= iss_done_nxt;
      rd_valid_r  <= rd_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r       <= job_nxt;
    k_r         <= k_nxt;
    rd_tag_r    <= k_r;
    max_r       <= max_nxt;
    cur_r       <= cur_nxt;
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
  end

endmodule

FILE: rtl/wnms_checker.sv
// port-level checks of the suppression block, bound to the top level
module wnms_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input wnms_pkg::sample_t               in_sample_value,
  input logic                            in_set_end,
  input logic                            out_valid,
  input logic                            out_ready,
  input wnms_pkg::sample_t               out_kept_value,
  input logic                            out_final_result,
  input logic                            cfg_valid,
  input logic                            cfg_ready,
  input logic [wnms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [wnms_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kept_value)
      && $stable(out_final_result))
    else $error("result changed while stalled");

  // a waiting input transaction keeps its payload
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_sample_value)
      && $stable(in_set_end))
    else $error("input changed while waiting");

  // register writes carry known index and data
  a_cfg_known: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> !$isunknown({cfg_index, cfg_data}))
    else $error("unknown register write");

  // one input transaction at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous one in work");

  // reset leaves no result and an open input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready && cfg_ready)
    else $error("bad state after reset");

endmodule

bind windowed_non_max_suppression_unit wnms_checker u_wnms_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_ready         (in_ready),
  .in_sample_value  (in_sample_value),
  .in_set_end       (in_set_end),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_kept_value   (out_kept_value),
  .out_final_result (out_final_result),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready),
  .cfg_index        (cfg_index),
  .cfg_data         (cfg_data)
);

FILE: sim/wnms_result_checker.sv
// checker for the suppression unit: predicts every result from the observed transactions
module wnms_result_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  wnms_pkg::sample_t               in_sample_value,
  input  logic                            in_set_end,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  wnms_pkg::sample_t               out_kept_value,
  input  logic                            out_final_result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wnms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wnms_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              outstanding,
  output int                              checked
);
  import wnms_pkg::*;

  localparam int HIST_DEPTH = 2 * MAX_RADIUS_DEF;

  typedef struct packed {
    sample_t kept;
    logic    last;
  } kept_result_t;

  sample_t           hist [MAX_CHANNELS_DEF][HIST_DEPTH];
  logic [SEEN_W-1:0] seen [MAX_CHANNELS_DEF];
  int                chan_pos;
  logic [RAD_W-1:0]  radius_reg;
  logic [CNT_W-1:0]  count_reg;
  kept_result_t      expected_kept [$];

  function automatic int eff_radius();
    int r;
    r = radius_reg;
    if (r < 1) r = 1;
    if (r > MAX_RADIUS_DEF) r = MAX_RADIUS_DEF;
    return r;
  endfunction

  function automatic int eff_count();
    int c;
    c = count_reg;
    if (c < 1) c = 1;
    if (c > MAX_CHANNELS_DEF) c = MAX_CHANNELS_DEF;
    return c;
  endfunction

  // keep the sample at this age unless a neighbour in its window is strictly greater
  function automatic sample_t window_verdict(input int ch, input int age, input int seen_n,
                                             input int rad);
    int      lo;
    int      hi;
    sample_t centre;
    bit      keep;
    if (seen_n == 0) return '0;
    lo = (age >= rad - 1) ? age - (rad - 1) : 0;
    hi = age + rad;
    if (hi > seen_n - 1) hi = seen_n - 1;
    if (hi > HIST_DEPTH - 1) hi = HIST_DEPTH - 1;
    centre = hist[ch][age % HIST_DEPTH];
    keep = 1'b1;
    for (int k = lo; k <= hi; k++) begin
      if (hist[ch][k] > centre) keep = 1'b0;
    end
    return keep ? centre : '0;
  endfunction

  task automatic append_kept(input sample_t value);
    kept_result_t item;
    item.kept = value;
    item.last = 1'b0;
    expected_kept.push_back(item);
  endtask

  task automatic predict_suppression(input sample_t sample, input logic set_end);
    int           rad;
    int           cnt;
    int           pos;
    int           s;
    int           sc;
    int           p;
    int           shift;
    bit           emitted;
    kept_result_t tail;
    rad = eff_radius();
    cnt = eff_count();
    pos = chan_pos;
    if (pos >= cnt) pos = 0;
    for (int k = HIST_DEPTH - 1; k > 0; k--) hist[pos][k] = hist[pos][k-1];
    hist[pos][0] = sample;
    if (seen[pos] < SEEN_MAX) seen[pos] = seen[pos] + 1'b1;
    s = seen[pos];
    emitted = 1'b0;
    if (s >= rad) begin
      append_kept(window_verdict(pos, rad - 1, s, rad));
      emitted = 1'b1;
    end
    if (set_end) begin
      // flush: oldest frame first, channels ascending, later channels one frame younger
      for (int k = MAX_RADIUS_DEF; k >= 0; k--) begin
        for (int ch = 0; ch < cnt; ch++) begin
          sc = seen[ch];
          p = (sc < rad - 1) ? sc : rad - 1;
          shift = (ch > pos) ? 1 : 0;
          if (k >= shift && k - shift < p) begin
            append_kept(window_verdict(ch, k - shift, sc, rad));
            emitted = 1'b1;
          end
        end
      end
      if (emitted) begin
        tail = expected_kept.pop_back();
        tail.last = 1'b1;
        expected_kept.push_back(tail);
      end
      for (int ch = 0; ch < MAX_CHANNELS_DEF; ch++) seen[ch] = '0;
      chan_pos = 0;
    end else begin
      chan_pos = (pos + 1 >= cnt) ? 0 : pos + 1;
    end
  endtask

  always @(posedge clk) begin
    kept_result_t want;
    if (!rst_n) begin
      for (int ch = 0; ch < MAX_CHANNELS_DEF; ch++) begin
        seen[ch] = '0;
        for (int k = 0; k < HIST_DEPTH; k++) hist[ch][k] = '0;
      end
      chan_pos = 0;
      radius_reg = RAD_W'(1);
      count_reg = CNT_W'(1);
      expected_kept.delete();
      fail_count = 0;
      checked = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_kept.size() == 0) begin
          fail_count++;
          $error("unexpected result: kept_value %0d final_result %0b",
                 out_kept_value, out_final_result);
        end else begin
          want = expected_kept.pop_front();
          checked++;
          if (out_kept_value !== want.kept) begin
            fail_count++;
            $error("kept_value: expected %0d, actual %0d", want.kept, out_kept_value);
          end
          if (out_final_result !== want.last) begin
            fail_count++;
            $error("final_result: expected %0b, actual %0b", want.last, out_final_result);
          end
        end
      end
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_WINDOW_RADIUS) radius_reg = cfg_data[RAD_W-1:0];
        else if (cfg_index == CFG_CHANNEL_COUNT) count_reg = cfg_data[CNT_W-1:0];
      end
      if (in_valid && in_ready) predict_suppression(in_sample_value, in_set_end);
    end
    outstanding <= expected_kept.size();
  end

endmodule

FILE: sim/testbench.sv
// top of the testbench: clock, reset, stimulus and verdict for the suppression unit
module testbench;
  import wnms_pkg::*;

  // cycles with no transaction on any channel before the run is declared hung
  localparam int STALL_LIMIT   = 4000;
  // quiet time before a register write or the end, covers a full flush decision
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_ITEMS  = 300;

  logic                  clk              = 1'b0;
  logic                  rst_n            = 1'b0;
  logic                  in_valid         = 1'b0;
  logic                  in_ready;
  sample_t               in_sample_value  = '0;
  logic                  in_set_end       = 1'b0;
  logic                  out_valid;
  logic                  out_ready        = 1'b0;
  sample_t               out_kept_value;
  logic                  out_final_result;
  logic                  cfg_valid        = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index        = CFG_WINDOW_RADIUS;
  logic [CFG_DATA_W-1:0] cfg_data         = '0;

  int fail_count;
  int outstanding;
  int checked;

  // bookkeeping of the stimulus side
  int items_sent  = 0;
  int sets_sent   = 0;
  int cfg_writes  = 0;
  int cnt_eff     = 1;
  int rx_hold     = 0;
  int idle_cycles = 0;
  bit steady_flow = 1'b0;  // when set, neither side inserts gaps

  always #5 clk = ~clk;

  windowed_non_max_suppression_unit uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kept_value   (out_kept_value),
    .out_final_result (out_final_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  wnms_result_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_value  (in_sample_value),
    .in_set_end       (in_set_end),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kept_value   (out_kept_value),
    .out_final_result (out_final_result),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .fail_count       (fail_count),
    .outstanding      (outstanding),
    .checked          (checked)
  );

  // result side: after each accepted transaction hold ready low for a random stretch
  always @(posedge clk) begin
    int stall;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_hold <= 0;
    end else if (out_valid && out_ready) begin
      stall = steady_flow ? 0 : $urandom_range(0, 15);
      rx_hold <= stall;
      out_ready <= (stall == 0);
    end else if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
      out_ready <= (rx_hold == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // one input transaction; valid is only dropped when a gap is drawn, so
  // back-to-back samples keep it high across the accepting edge
  task automatic send_sample(input sample_t value, input logic last);
    int gap;
    gap = steady_flow ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_value <= value;
    in_set_end <= last;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (last) sets_sent++;
  endtask

  // stop sending, let every predicted result drain, then allow the block to go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // both registers in back-to-back transactions, valid held high between them
  task automatic write_config(input logic [CFG_DATA_W-1:0] rad_val,
                              input logic [CFG_DATA_W-1:0] cnt_val);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_WINDOW_RADIUS;
    cfg_data <= rad_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_index <= CFG_CHANNEL_COUNT;
    cfg_data <= cnt_val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes += 2;
    // track the channel count the block really uses, for sizing the data sets
    cnt_eff = int'(cnt_val[CNT_W-1:0]);
    if (cnt_eff < 1) cnt_eff = 1;
    if (cnt_eff > MAX_CHANNELS_DEF) cnt_eff = MAX_CHANNELS_DEF;
  endtask

  // sample flavours: full random, tightly clustered values full of ties, extremes
  function automatic sample_t pick_sample(input int flavour);
    case (flavour)
      0: return sample_t'($urandom);
      1: return sample_t'(int'($urandom_range(0, 3)) - 1);
      default: begin
        case ($urandom_range(0, 4))
          0: return 32'sh7fff_ffff;
          1: return 32'sh8000_0000;
          2: return '0;
          3: return -32'sd1;
          default: return sample_t'($urandom);
        endcase
      end
    endcase
  endfunction

  task automatic send_run(input int n, input int flavour, input bit close_set);
    for (int i = 0; i < n; i++) send_sample(pick_sample(flavour), close_set && (i == n - 1));
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_radius();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(MAX_RADIUS_DEF);
      2: return CFG_DATA_W'($urandom_range(MAX_RADIUS_DEF + 1, 31));
      default: return CFG_DATA_W'($urandom_range(1, 5));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] draw_count();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_DATA_W'(MAX_CHANNELS_DEF);
      2: return CFG_DATA_W'($urandom_range(MAX_CHANNELS_DEF + 1, 31));
      default: return CFG_DATA_W'($urandom_range(1, MAX_CHANNELS_DEF));
    endcase
  endfunction

  initial begin
    int dir_items;
    int n;
    int cut;
    int flavour;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // directed: reset settings, radius one compares each sample with its predecessor
    steady_flow = 1'b1;
    send_sample(32'sh7fff_ffff, 1'b0);
    send_sample(32'sh8000_0000, 1'b0);
    send_sample(32'sh0000_0000, 1'b0);
    send_sample(-32'sd1, 1'b1);
    settle();

    // two channels, radius three, equal peaks must both survive
    steady_flow = 1'b0;
    write_config(CFG_DATA_W'(3), CFG_DATA_W'(2));
    send_sample(32'sd10, 1'b0);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sd10, 1'b0);
    send_sample(-32'sd5, 1'b0);
    send_sample(32'sd3, 1'b0);
    send_sample(-32'sd4, 1'b0);
    send_sample(32'sd10, 1'b0);
    send_sample(-32'sd5, 1'b1);
    settle();

    // end mark on the first channel of a frame cuts the frame short
    write_config(CFG_DATA_W'(2), CFG_DATA_W'(3));
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(-32'sh0001_0000, 1'b0);
    send_sample(32'sh0000_8000, 1'b0);
    send_sample(32'sh0002_0000, 1'b1);
    settle();

    // settings changed in the middle of a set; the channel position goes stale
    write_config(CFG_DATA_W'(2), CFG_DATA_W'(2));
    send_sample(32'sd7, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sd9, 1'b0);
    settle();
    write_config(CFG_DATA_W'(4), CFG_DATA_W'(1));
    send_sample(32'sd2, 1'b0);
    send_sample(32'sd9, 1'b0);
    send_sample(32'sd8, 1'b1);
    settle();

    // zero in both registers acts as one
    write_config('0, '0);
    send_sample(-32'sd3, 1'b0);
    send_sample(32'sd3, 1'b1);
    settle();
    dir_items = items_sent;

    // random data sets: mostly well formed, some with the end mark off the last
    // channel, some split by a settings change, now and then a long single-channel set
    while (items_sent - dir_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1) == 0) begin
        settle();
        write_config(draw_radius(), draw_count());
      end
      steady_flow = ($urandom_range(0, 3) == 0);
      flavour = $urandom_range(0, 2);
      if (cnt_eff == 1 && $urandom_range(0, 14) == 0) n = 66;
      else n = cnt_eff * $urandom_range(1, 10);
      if ($urandom_range(0, 5) == 0) n = $urandom_range(1, n + cnt_eff);
      if (n > 2 && $urandom_range(0, 7) == 0) begin
        cut = $urandom_range(1, n - 1);
        send_run(cut, flavour, 1'b0);
        settle();
        write_config(draw_radius(), draw_count());
        send_run(n - cut, flavour, 1'b1);
      end else begin
        send_run(n, flavour, 1'b1);
      end
    end
    settle();

    $display("summary: %0d samples in %0d data sets, %0d register writes",
             items_sent, sets_sent, cfg_writes);
    $display("summary: %0d results compared, %0d mismatches", checked, fail_count);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/wnms_pkg.sv
rtl/wnms_queue.sv
rtl/wnms_front.sv
rtl/wnms_back.sv
rtl/windowed_non_max_suppression_unit.sv
rtl/wnms_checker.sv
sim/wnms_result_checker.sv
sim/testbench.sv
